### sv/ascon_pkg.sv
// Shared types, constants and functions of the Ascon AEAD engine.
`default_nettype none
package ascon_pkg;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_AD    = 2'd1;
  localparam logic [1:0] FUNC_MSG   = 2'd2;
  localparam logic [1:0] FUNC_FIN   = 2'd3;

  localparam logic [1:0] VAR_128   = 2'd1 - 2'd1;
  localparam logic [1:0] VAR_128A  = 2'd1;
  localparam logic [1:0] VAR_80PQ  = 2'd2;

  localparam logic [2:0] REG_VARIANT  = 3'd0;
  localparam logic [2:0] REG_DECRYPT  = 3'd1;
  localparam logic [2:0] REG_KEY_TOP  = 3'd2;
  localparam logic [2:0] REG_KEY_HIGH = 3'd3;
  localparam logic [2:0] REG_KEY_LOW  = 3'd4;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_AD   = 2'd1;
  localparam logic [1:0] PH_MSG  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [63:0] IV_128  = 64'h80400c0600000000;
  localparam logic [63:0] IV_128A = 64'h80800c0800000000;
  localparam logic [63:0] IV_80PQ = 64'ha0400c0600000000;

  typedef logic [63:0] lane_t;
  typedef lane_t [4:0] state_t;

  // One permutation round with round index rnd (0..11).
  function automatic state_t ascon_round(input state_t s, input logic [3:0] rnd);
    state_t x;
    lane_t t0, t1, t2, t3, t4;
    x = s;
    x[2] = x[2] ^ {56'd0, 4'd15 - rnd, rnd};
    x[0] = x[0] ^ x[4]; x[4] = x[4] ^ x[3]; x[2] = x[2] ^ x[1];
    t0 = ~x[0] & x[1]; t1 = ~x[1] & x[2]; t2 = ~x[2] & x[3];
    t3 = ~x[3] & x[4]; t4 = ~x[4] & x[0];
    x[0] = x[0] ^ t1; x[1] = x[1] ^ t2; x[2] = x[2] ^ t3;
    x[3] = x[3] ^ t4; x[4] = x[4] ^ t0;
    x[1] = x[1] ^ x[0]; x[0] = x[0] ^ x[4]; x[3] = x[3] ^ x[2]; x[2] = ~x[2];
    x[0] = x[0] ^ {x[0][18:0], x[0][63:19]} ^ {x[0][27:0], x[0][63:28]};
    x[1] = x[1] ^ {x[1][60:0], x[1][63:61]} ^ {x[1][38:0], x[1][63:39]};
    x[2] = x[2] ^ {x[2][0], x[2][63:1]} ^ {x[2][5:0], x[2][63:6]};
    x[3] = x[3] ^ {x[3][9:0], x[3][63:10]} ^ {x[3][16:0], x[3][63:17]};
    x[4] = x[4] ^ {x[4][6:0], x[4][63:7]} ^ {x[4][40:0], x[4][63:41]};
    return x;
  endfunction

  // Leading n bytes (n in 0..8) of a big-endian word.
  function automatic lane_t lead_mask(input logic [3:0] n);
    lane_t m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) m[63-8*i -: 8] = 8'hff;
    end
    return m;
  endfunction

  // Padding byte at byte position pos of a word.
  function automatic lane_t pad_word(input logic [2:0] pos);
    lane_t p;
    p = '0;
    p[63 - 8*pos] = 1'b1;
    return p;
  endfunction

endpackage
`default_nettype wire

### sv/ascon_if.sv
// Valid/ready channel interfaces of the Ascon AEAD engine.
`default_nettype none
interface ascon_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] data_hi;
  logic [63:0] data_lo;
  logic [4:0]  nbytes;
  logic        last_block;
  modport source (output valid, func, data_hi, data_lo, nbytes, last_block, input ready);
  modport sink (input valid, func, data_hi, data_lo, nbytes, last_block, output ready);
endinterface

interface ascon_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_hi;
  logic [63:0] out_lo;
  logic [4:0]  out_bytes;
  logic        is_tag;
  logic        tag_ok;
  modport source (output valid, out_hi, out_lo, out_bytes, is_tag, tag_ok, input ready);
  modport sink (input valid, out_hi, out_lo, out_bytes, is_tag, tag_ok, output ready);
endinterface

interface ascon_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/ascon_perm.sv
// Ascon state register with a shared one-round permutation unit.
`default_nettype none
module ascon_perm
  import ascon_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       load,
  input  wire state_t     load_val,
  input  wire logic       step,
  input  wire logic [3:0] rnd,
  output state_t          st
);
  always_ff @(posedge clk) begin
    if (load) begin
      st <= load_val;
    end else if (step) begin
      st <= ascon_round(st, rnd);
    end
  end
endmodule
`default_nettype wire

### sv/ascon_aead_engine_unit.sv
// Top level of the Ascon AEAD engine (128, 128a, 80pq; encrypt and decrypt).
//
//  channel  dir  payload                                   handshake
//  cfg      in   index[2:0], data[63:0]                    valid/ready
//  in       in   func, data_hi, data_lo, nbytes, last_block valid/ready
//  out      out  out_hi, out_lo, out_bytes, is_tag, tag_ok valid/ready
//
// The shared round unit does one permutation round per clock. Start and
// finalize take 12 rounds, a data block 6 (rate 8) or 8 (rate 16); an implied
// AD close adds one more block run.
// Reset (rst, synchronous) sets the phase to idle; each start item loads
// every lane, so the lanes need no clearing.
// The input is not ready while an item is in work or a result waits on out.
`default_nettype none
module ascon_aead_engine_unit
  import ascon_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  ascon_cfg_if.sink     cfg,
  ascon_in_if.sink      in_ch,
  ascon_out_if.source   out_ch
);
  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PERM  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;

  // Step codes: what follows the current permutation run.
  localparam logic [2:0] NX_NONE    = 3'd0; // fresh item
  localparam logic [2:0] NX_STARTK  = 3'd1; // key after start
  localparam logic [2:0] NX_DONE    = 3'd2; // run over, item done
  localparam logic [2:0] NX_MSGBLK  = 3'd3; // message block, after any AD close
  localparam logic [2:0] NX_FIN     = 3'd4; // finalize, after any AD close
  localparam logic [2:0] NX_FINK    = 3'd5; // key after finalize run
  localparam logic [2:0] NX_ADLAST  = 3'd6; // last AD run done: close
  localparam logic [2:0] NX_MSGLAST = 3'd7; // full last msg: pad

  logic [1:0]  variant;
  logic        decrypt_mode;
  logic [31:0] key_top;
  logic [63:0] key_high, key_low;

  logic [2:0]  state;
  logic [1:0]  phase;
  logic        ad_absorbed;
  logic [2:0]  nxt;
  logic [3:0]  rnd;
  logic        res_pend;

  // Held item.
  logic [1:0]  func;
  logic [63:0] dhi, dlo;
  logic [4:0]  nb;
  logic        last;

  state_t st, ld_val;
  logic   ld, step;

  logic [4:0]  rate;
  logic [3:0]  first_rnd;
  logic [4:0]  n;

  assign rate      = (variant == VAR_128A) ? 5'd16 : 5'd8;
  assign first_rnd = (variant == VAR_128A) ? 4'd4 : 4'd6;
  assign n = !last ? rate : ((nb > rate) ? rate : nb);

  ascon_perm u_perm (
    .clk(clk), .load(ld), .load_val(ld_val), .step(step), .rnd(rnd), .st(st)
  );

  assign cfg.ready   = (state == S_IDLE);
  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= '0; decrypt_mode <= 1'b0;
      key_top <= '0; key_high <= '0; key_low <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_VARIANT:  variant <= cfg.data[1:0];
        REG_DECRYPT:  decrypt_mode <= cfg.data[0];
        REG_KEY_TOP:  key_top <= cfg.data[31:0];
        REG_KEY_HIGH: key_high <= cfg.data;
        REG_KEY_LOW:  key_low <= cfg.data;
        default: ;
      endcase
    end
  end

  // Block absorb helpers.
  logic [3:0]  n0, n1;
  lane_t       m0, m1, d0, d1, p0, p1;
  assign n0 = (n > 5'd8) ? 4'd8 : n[3:0];
  assign n1 = (rate == 5'd16 && n > 5'd8) ? 4'(n - 5'd8) : 4'd0;
  assign m0 = lead_mask(n0);
  assign m1 = lead_mask(n1);
  assign d0 = dhi & m0;
  assign d1 = dlo & m1;
  assign p0 = st[0] ^ d0;
  assign p1 = st[1] ^ d1;

  logic [63:0] ohi, olo;
  logic [4:0]  obytes;
  logic        otag, ook;

  assign out_ch.valid     = (state == S_OUT);
  assign out_ch.out_hi    = ohi;
  assign out_ch.out_lo    = olo;
  assign out_ch.out_bytes = obytes;
  assign out_ch.is_tag    = otag;
  assign out_ch.tag_ok    = ook;

  // Combinational state update chosen per dispatch action.
  state_t      s_new;
  logic [2:0]  state_next, nxt_next;
  logic [1:0]  phase_next;
  logic        ad_next;
  logic        run;      // start a permutation run after this load
  logic        run12;
  logic        emit;
  logic [63:0] e_hi, e_lo;
  logic [4:0]  e_bytes;
  logic        e_tag, e_ok;

  always_comb begin
    s_new = st; state_next = state; nxt_next = nxt; phase_next = phase;
    ad_next = ad_absorbed; run = 1'b0; run12 = 1'b0; emit = 1'b0;
    e_hi = '0; e_lo = '0; e_bytes = '0; e_tag = 1'b0; e_ok = 1'b0;
    ld = 1'b0;
    if (state == S_DISP) begin
      ld = 1'b1;
      state_next = S_IDLE;
      case (nxt)
        NX_NONE: begin
          // Fresh item: pick the first action.
          case (func)
            FUNC_START: begin
              s_new[0] = (variant == VAR_80PQ) ? (IV_80PQ ^ {32'd0, key_top}) :
                         (variant == VAR_128A) ? IV_128A : IV_128;
              s_new[1] = key_high; s_new[2] = key_low; s_new[3] = dhi; s_new[4] = dlo;
              run = 1'b1; run12 = 1'b1; nxt_next = NX_STARTK;
              phase_next = PH_AD; ad_next = 1'b0;
            end
            FUNC_AD: begin
              if (phase != PH_AD) begin
                ld = 1'b0;
              end else if (n == rate) begin
                s_new[0] = p0;
                if (rate == 5'd16) s_new[1] = p1;
                run = 1'b1; ad_next = 1'b1;
                nxt_next = last ? NX_ADLAST : NX_DONE;
              end else if (n != 5'd0) begin
                s_new[0] = p0;
                if (rate == 5'd16) s_new[1] = p1;
                if (n[3]) s_new[1] = s_new[1] ^ pad_word(n[2:0]);
                else      s_new[0] = s_new[0] ^ pad_word(n[2:0]);
                run = 1'b1; nxt_next = NX_ADLAST; ad_next = 1'b0;
              end else begin
                if (ad_absorbed) begin
                  s_new[0] = st[0] ^ pad_word(3'd0);
                  run = 1'b1; nxt_next = NX_ADLAST; ad_next = 1'b0;
                end else begin
                  s_new[4] = st[4] ^ 64'd1; phase_next = PH_MSG;
                end
              end
            end
            FUNC_MSG, FUNC_FIN: begin
              if (phase == PH_IDLE || (func == FUNC_MSG && phase == PH_DONE)) begin
                ld = 1'b0;
              end else if (phase == PH_AD) begin
                if (ad_absorbed) begin
                  // Pad and run, then domain separation before the block or finalize.
                  s_new[0] = st[0] ^ pad_word(3'd0);
                  run = 1'b1; ad_next = 1'b0;
                  nxt_next = NX_ADLAST;
                end else begin
                  s_new[4] = st[4] ^ 64'd1; phase_next = PH_MSG;
                  state_next = S_DISP;
                  nxt_next = (func == FUNC_MSG) ? NX_MSGBLK : NX_FIN;
                end
              end else begin
                state_next = S_DISP;
                ld = 1'b0;
                nxt_next = (func == FUNC_MSG) ? NX_MSGBLK : NX_FIN;
              end
            end
            default: ld = 1'b0;
          endcase
        end
        NX_STARTK: begin
          if (variant == VAR_80PQ) s_new[2] = st[2] ^ {32'd0, key_top};
          s_new[3] = st[3] ^ key_high; s_new[4] = st[4] ^ key_low;
          nxt_next = NX_NONE;
        end
        NX_ADLAST: begin
          // Full last AD block done or padded close done.
          if (ad_absorbed && func == FUNC_AD && last && n == rate) begin
            s_new[0] = st[0] ^ pad_word(3'd0);
            run = 1'b1; ad_next = 1'b0; nxt_next = NX_ADLAST;
          end else begin
            s_new[4] = st[4] ^ 64'd1; phase_next = PH_MSG; nxt_next = NX_NONE;
            if (func == FUNC_MSG) begin
              state_next = S_DISP; nxt_next = NX_MSGBLK;
            end else if (func == FUNC_FIN) begin
              state_next = S_DISP; nxt_next = NX_FIN;
            end
          end
        end
        NX_DONE: begin
          nxt_next = NX_NONE; ld = 1'b0;
        end
        NX_MSGBLK: begin
          s_new[0] = decrypt_mode ? ((st[0] & ~m0) | d0) : p0;
          if (rate == 5'd16) s_new[1] = decrypt_mode ? ((st[1] & ~m1) | d1) : p1;
          emit = 1'b1;
          e_hi = p0 & m0;
          e_lo = (rate == 5'd16) ? (p1 & m1) : 64'd0;
          e_bytes = n;
          if (n == rate) begin
            run = 1'b1;
            nxt_next = last ? NX_MSGLAST : NX_DONE;
            if (last) phase_next = PH_DONE;
          end else begin
            if (n[3]) s_new[1] = s_new[1] ^ pad_word(n[2:0]);
            else      s_new[0] = s_new[0] ^ pad_word(n[2:0]);
            phase_next = PH_DONE; nxt_next = NX_NONE;
          end
        end
        NX_MSGLAST: begin
          s_new[0] = st[0] ^ pad_word(3'd0); nxt_next = NX_NONE;
        end
        NX_FIN: begin
          if (phase == PH_MSG) s_new[0] = st[0] ^ pad_word(3'd0);
          if (variant == VAR_80PQ) begin
            s_new[1] = st[1] ^ {key_top, key_high[63:32]};
            s_new[2] = st[2] ^ {key_high[31:0], key_low[63:32]};
            s_new[3] = st[3] ^ {key_low[31:0], 32'd0};
          end else if (variant == VAR_128A) begin
            s_new[2] = st[2] ^ key_high; s_new[3] = st[3] ^ key_low;
          end else begin
            s_new[1] = st[1] ^ key_high; s_new[2] = st[2] ^ key_low;
          end
          run = 1'b1; run12 = 1'b1; nxt_next = NX_FINK;
        end
        NX_FINK: begin
          s_new[3] = st[3] ^ key_high; s_new[4] = st[4] ^ key_low;
          emit = 1'b1; e_tag = 1'b1;
          if (decrypt_mode) begin
            e_ok = (s_new[3] == dhi) && (s_new[4] == dlo);
          end else begin
            e_hi = s_new[3]; e_lo = s_new[4]; e_bytes = 5'd16;
          end
          phase_next = PH_IDLE; ad_next = 1'b0; nxt_next = NX_NONE;
        end
        default: ld = 1'b0;
      endcase
      // Present a held result once the item has no more runs to do.
      if (run) state_next = S_PERM;
      else if ((emit || res_pend) && state_next == S_IDLE) state_next = S_OUT;
    end
  end

  assign ld_val = s_new;
  assign step   = (state == S_PERM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; phase <= PH_IDLE; ad_absorbed <= 1'b0;
      nxt <= NX_NONE; rnd <= '0; res_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            state <= S_DISP; nxt <= NX_NONE;
          end
        end
        S_DISP: begin
          state <= state_next; nxt <= nxt_next;
          phase <= phase_next; ad_absorbed <= ad_next;
          rnd <= run12 ? 4'd0 : first_rnd;
          if (emit) res_pend <= 1'b1;
        end
        S_PERM: begin
          // Advance one round; the run ends at round eleven.
          rnd <= rnd + 4'd1;
          if (rnd == 4'd11) state <= S_DISP;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state <= S_IDLE; res_pend <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold item and result payloads.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func <= in_ch.func; dhi <= in_ch.data_hi; dlo <= in_ch.data_lo;
      nb <= in_ch.nbytes; last <= in_ch.last_block;
    end
    if (state == S_DISP && emit) begin
      ohi <= e_hi; olo <= e_lo; obytes <= e_bytes; otag <= e_tag; ook <= e_ok;
    end
  end
endmodule
`default_nettype wire

### tb/ascon_aead_engine_unit_sb.sv
// Scoreboard class: Ascon AEAD predictor and queue of expected results.
`timescale 1ns / 100ps
package ascon_tb_pkg;
  import ascon_pkg::*;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic [4:0]  out_bytes;
    logic        is_tag;
    logic        tag_ok;
  } aead_result_t;

  class aead_scoreboard;
    logic [63:0] lane [5];
    logic [1:0]  cur_phase;
    bit          ad_seen;
    logic [1:0]  variant_r;
    bit          decrypt_r;
    logic [31:0] key_top_r;
    logic [63:0] key_high_r, key_low_r;
    aead_result_t pending_results[$];
    int          mismatches;

    function new();
      for (int i = 0; i < 5; i++) lane[i] = '0;
      cur_phase = PH_IDLE; ad_seen = 0;
      variant_r = VAR_128; decrypt_r = 0;
      key_top_r = '0; key_high_r = '0; key_low_r = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        REG_VARIANT:  variant_r = value[1:0];
        REG_DECRYPT:  decrypt_r = value[0];
        REG_KEY_TOP:  key_top_r = value[31:0];
        REG_KEY_HIGH: key_high_r = value;
        REG_KEY_LOW:  key_low_r = value;
        default: ;
      endcase
    endfunction

    function logic [63:0] rotr(logic [63:0] x, int r);
      return (x >> r) | (x << (64 - r));
    endfunction

    function void run_rounds(int rounds);
      logic [63:0] t0, t1, t2, t3, t4;
      for (int i = 12 - rounds; i < 12; i++) begin
        lane[2] ^= 64'(((15 - i) << 4) | i);
        lane[0] ^= lane[4]; lane[4] ^= lane[3]; lane[2] ^= lane[1];
        t0 = ~lane[0] & lane[1]; t1 = ~lane[1] & lane[2]; t2 = ~lane[2] & lane[3];
        t3 = ~lane[3] & lane[4]; t4 = ~lane[4] & lane[0];
        lane[0] ^= t1; lane[1] ^= t2; lane[2] ^= t3; lane[3] ^= t4; lane[4] ^= t0;
        lane[1] ^= lane[0]; lane[0] ^= lane[4]; lane[3] ^= lane[2]; lane[2] = ~lane[2];
        lane[0] ^= rotr(lane[0], 19) ^ rotr(lane[0], 28);
        lane[1] ^= rotr(lane[1], 61) ^ rotr(lane[1], 39);
        lane[2] ^= rotr(lane[2], 1) ^ rotr(lane[2], 6);
        lane[3] ^= rotr(lane[3], 10) ^ rotr(lane[3], 17);
        lane[4] ^= rotr(lane[4], 7) ^ rotr(lane[4], 41);
      end
    endfunction

    function int rate();
      return (variant_r == VAR_128A) ? 16 : 8;
    endfunction

    function int block_rounds();
      return (variant_r == VAR_128A) ? 8 : 6;
    endfunction

    function logic [63:0] byte_mask(int n);
      if (n <= 0) return '0;
      if (n >= 8) return '1;
      return ~64'd0 << (64 - 8 * n);
    endfunction

    function logic [63:0] absorb_lane(int w, logic [63:0] d, int n, bit dec);
      logic [63:0] m, p;
      m = byte_mask(n);
      d &= m;
      p = lane[w] ^ d;
      lane[w] = dec ? ((lane[w] & ~m) | d) : p;
      return p & m;
    endfunction

    function void absorb_block(int n, logic [63:0] hi, logic [63:0] lo, bit dec,
                               output logic [63:0] ohi, output logic [63:0] olo);
      int n0;
      n0 = n > 8 ? 8 : n;
      ohi = absorb_lane(0, hi, n0, dec);
      olo = (rate() == 16) ? absorb_lane(1, lo, n - n0, dec) : '0;
    endfunction

    function void add_pad(int n);
      lane[n >= 8 ? 1 : 0] ^= 64'h80 << (56 - 8 * (n & 7));
    endfunction

    function void close_ad();
      if (ad_seen) begin
        add_pad(0);
        run_rounds(block_rounds());
      end
      lane[4] ^= 64'd1;
      cur_phase = PH_MSG;
    endfunction

    // Advance the model by one accepted input item; queue any result.
    function void note_input(logic [1:0] func, logic [63:0] hi, logic [63:0] lo,
                             logic [4:0] nb, bit last);
      int r, n;
      logic [63:0] ohi, olo;
      aead_result_t res;
      r = rate();
      n = last ? (int'(nb) > r ? r : int'(nb)) : r;
      case (func)
        FUNC_START: begin
          if (variant_r == VAR_80PQ) lane[0] = IV_80PQ ^ {32'd0, key_top_r};
          else if (variant_r == VAR_128A) lane[0] = IV_128A;
          else lane[0] = IV_128;
          lane[1] = key_high_r; lane[2] = key_low_r; lane[3] = hi; lane[4] = lo;
          run_rounds(12);
          if (variant_r == VAR_80PQ) lane[2] ^= {32'd0, key_top_r};
          lane[3] ^= key_high_r; lane[4] ^= key_low_r;
          cur_phase = PH_AD; ad_seen = 0;
        end
        FUNC_AD: begin
          if (cur_phase == PH_AD) begin
            if (n == r) begin
              absorb_block(n, hi, lo, 0, ohi, olo);
              run_rounds(block_rounds());
              ad_seen = 1;
              if (last) close_ad();
            end else if (n > 0) begin
              absorb_block(n, hi, lo, 0, ohi, olo);
              add_pad(n);
              run_rounds(block_rounds());
              lane[4] ^= 64'd1;
              cur_phase = PH_MSG;
            end else close_ad();
          end
        end
        FUNC_MSG: begin
          if (cur_phase == PH_AD || cur_phase == PH_MSG) begin
            if (cur_phase == PH_AD) close_ad();
            absorb_block(n, hi, lo, decrypt_r, ohi, olo);
            if (n == r) begin
              run_rounds(block_rounds());
              if (last) begin add_pad(0); cur_phase = PH_DONE; end
            end else begin
              add_pad(n);
              cur_phase = PH_DONE;
            end
            res = '{ohi, olo, 5'(n), 1'b0, 1'b0};
            pending_results.push_back(res);
          end
        end
        default: begin
          if (cur_phase != PH_IDLE) begin
            if (cur_phase == PH_AD) close_ad();
            if (cur_phase == PH_MSG) add_pad(0);
            if (variant_r == VAR_80PQ) begin
              lane[1] ^= {key_top_r, key_high_r[63:32]};
              lane[2] ^= {key_high_r[31:0], key_low_r[63:32]};
              lane[3] ^= {key_low_r[31:0], 32'd0};
            end else if (variant_r == VAR_128A) begin
              lane[2] ^= key_high_r; lane[3] ^= key_low_r;
            end else begin
              lane[1] ^= key_high_r; lane[2] ^= key_low_r;
            end
            run_rounds(12);
            lane[3] ^= key_high_r; lane[4] ^= key_low_r;
            if (decrypt_r)
              res = '{64'd0, 64'd0, 5'd0, 1'b1, (lane[3] == hi && lane[4] == lo)};
            else
              res = '{lane[3], lane[4], 5'd16, 1'b1, 1'b0};
            pending_results.push_back(res);
            cur_phase = PH_IDLE; ad_seen = 0;
          end
        end
      endcase
    endfunction

    // Compare one accepted result against the oldest expectation.
    function void check_result(aead_result_t got);
      aead_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result item %p", got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.out_hi !== want.out_hi) begin
        $error("out_hi expected %h actual %h", want.out_hi, got.out_hi); mismatches++;
      end
      if (got.out_lo !== want.out_lo) begin
        $error("out_lo expected %h actual %h", want.out_lo, got.out_lo); mismatches++;
      end
      if (got.out_bytes !== want.out_bytes) begin
        $error("out_bytes expected %0d actual %0d", want.out_bytes, got.out_bytes);
        mismatches++;
      end
      if (got.is_tag !== want.is_tag) begin
        $error("is_tag expected %b actual %b", want.is_tag, got.is_tag); mismatches++;
      end
      if (got.tag_ok !== want.tag_ok) begin
        $error("tag_ok expected %b actual %b", want.tag_ok, got.tag_ok); mismatches++;
      end
    endfunction
  endclass
endpackage

### tb/ascon_aead_engine_unit_tb.sv
// Testbench top: drives the Ascon AEAD engine and checks its results.
`timescale 1ns / 100ps
module ascon_aead_engine_unit_tb;
  import ascon_pkg::*;
  import ascon_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  always #2 clk = ~clk;

  ascon_cfg_if cfg ();
  ascon_in_if  in_ch ();
  ascon_out_if out_ch ();

  ascon_aead_engine_unit dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  aead_scoreboard sb = new();

  // Idle percentages for sender and receiver, set by phase of the run.
  int send_idle_pct = 19;
  int recv_idle_pct = 77;

  // Tag the decrypt side can match: filled from each encrypt tag seen.
  logic [63:0] last_tag_hi = '0, last_tag_lo = '0;

  initial begin
    cfg.valid = 0; cfg.index = REG_VARIANT; cfg.data = '0;
    in_ch.valid = 0; in_ch.func = FUNC_START; in_ch.data_hi = '0; in_ch.data_lo = '0;
    in_ch.nbytes = '0; in_ch.last_block = 0;
    out_ch.ready = 0;
  end

  // Receiver: sample at the rising edge, set ready at random at the falling edge.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_ch.out_hi, out_ch.out_lo, out_ch.out_bytes,
                        out_ch.is_tag, out_ch.tag_ok});
      if (out_ch.is_tag && out_ch.out_bytes == 5'd16) begin
        last_tag_hi = out_ch.out_hi; last_tag_lo = out_ch.out_lo;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Write one register through the config channel.
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  // Send one input item; hold it until accepted, with random idle gaps before.
  task automatic send_item(logic [1:0] func, logic [63:0] hi, logic [63:0] lo,
                           logic [4:0] nb, bit last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1; in_ch.func <= func; in_ch.data_hi <= hi; in_ch.data_lo <= lo;
    in_ch.nbytes <= nb; in_ch.last_block <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(func, hi, lo, nb, last);
    // Drop valid at the next falling edge; the engine is busy then anyway.
    @(negedge clk);
    in_ch.valid <= 0;
  endtask

  // Wait for every expected result, then let the engine settle.
  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One well-formed operation: start, AD blocks, message blocks, finalize.
  task automatic run_operation(bit use_tag);
    int n_ad, n_msg, r;
    logic [4:0] nb;
    r = (sb.variant_r == VAR_128A) ? 16 : 8;
    send_item(FUNC_START, rand64(), rand64(), 5'($urandom_range(31)),
              1'($urandom_range(1)));
    n_ad = $urandom_range(3);
    for (int i = 0; i < n_ad; i++) begin
      nb = (i == n_ad - 1) ? 5'($urandom_range(r)) : 5'($urandom_range(31));
      send_item(FUNC_AD, rand64(), rand64(), nb, i == n_ad - 1);
    end
    n_msg = $urandom_range(3);
    for (int i = 0; i < n_msg; i++) begin
      nb = (i == n_msg - 1) ? 5'($urandom_range(r)) : 5'($urandom_range(31));
      send_item(FUNC_MSG, rand64(), rand64(), nb, i == n_msg - 1 && $urandom_range(3) != 0);
    end
    if (use_tag) send_item(FUNC_FIN, last_tag_hi, last_tag_lo, '0, 1'b0);
    else send_item(FUNC_FIN, rand64(), rand64(), 5'($urandom_range(31)),
                   1'($urandom_range(1)));
  endtask

  task automatic random_phase(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) < 8) begin
        run_operation(1'($urandom_range(1)));
        sent += 5;
      end else begin
        send_item(2'($urandom_range(3)), rand64(), rand64(), 5'($urandom_range(31)),
                  1'($urandom_range(1)));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: items before start, all variants, extreme keys.
    send_item(FUNC_AD, '1, '1, 5'd8, 1'b1);
    send_item(FUNC_MSG, '1, '1, 5'd8, 1'b1);
    send_item(FUNC_FIN, '0, '0, 5'd0, 1'b0);
    drain();
    write_reg(REG_KEY_TOP, '1);
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_DECRYPT, 64'd0);
    // Ascon-128, full last AD block, full last message block, oversize nbytes.
    send_item(FUNC_START, '0, '0, 5'd0, 1'b0);
    send_item(FUNC_AD, '1, '1, 5'd8, 1'b1);
    send_item(FUNC_AD, '1, '1, 5'd8, 1'b1);
    send_item(FUNC_MSG, '1, '1, 5'd31, 1'b1);
    send_item(FUNC_MSG, '1, '1, 5'd3, 1'b1);
    send_item(FUNC_FIN, '0, '0, 5'd0, 1'b0);
    // Empty AD, then finalize with message still open.
    send_item(FUNC_START, '1, '1, 5'd16, 1'b1);
    send_item(FUNC_AD, '0, '0, 5'd0, 1'b1);
    send_item(FUNC_MSG, 64'h0123456789abcdef, '0, 5'd8, 1'b0);
    send_item(FUNC_FIN, '0, '0, 5'd0, 1'b0);
    // Missing last marker on AD, restart mid-operation.
    send_item(FUNC_START, rand64(), rand64(), 5'd0, 1'b0);
    send_item(FUNC_AD, rand64(), rand64(), 5'd8, 1'b0);
    send_item(FUNC_START, rand64(), rand64(), 5'd0, 1'b0);
    send_item(FUNC_AD, rand64(), rand64(), 5'd8, 1'b0);
    send_item(FUNC_FIN, '0, '0, 5'd0, 1'b0);
    drain();
    write_reg(REG_VARIANT, {62'd0, VAR_128A});
    write_reg(REG_KEY_HIGH, '0);
    write_reg(REG_KEY_LOW, '0);
    send_item(FUNC_START, '1, '0, 5'd0, 1'b0);
    send_item(FUNC_AD, '1, '1, 5'd12, 1'b1);
    send_item(FUNC_MSG, '1, '1, 5'd16, 1'b1);
    send_item(FUNC_FIN, '0, '0, 5'd0, 1'b0);
    drain();
    write_reg(REG_VARIANT, {62'd0, VAR_80PQ});
    write_reg(REG_DECRYPT, 64'd1);
    send_item(FUNC_START, '0, '1, 5'd0, 1'b0);
    send_item(FUNC_MSG, '1, '1, 5'd5, 1'b1);
    send_item(FUNC_AD, '1, '1, 5'd5, 1'b1);
    send_item(FUNC_FIN, '1, '1, 5'd0, 1'b0);
    drain();
    write_reg(REG_VARIANT, 64'd3);

    // Random phases; rewrite registers between them.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 77; recv_idle_pct = 19; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int k = 0; k < 5; k++) begin
        write_reg(REG_VARIANT, 64'($urandom_range(3)));
        write_reg(REG_DECRYPT, 64'($urandom_range(1)));
        write_reg(REG_KEY_TOP, rand64());
        write_reg(REG_KEY_HIGH, rand64());
        write_reg(REG_KEY_LOW, rand64());
        // Run random operations with this variant, mode and key.
        random_phase(60);
      end
    end
    drain();
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

### ascon_aead_engine_unit.f
sv/ascon_pkg.sv
sv/ascon_if.sv
sv/ascon_perm.sv
sv/ascon_aead_engine_unit.sv
tb/ascon_aead_engine_unit_sb.sv
tb/ascon_aead_engine_unit_tb.sv
